// ----- design/relay_schedule_countdown_timer_macros.svh -----
// assertion macros for the relay schedule countdown timer
`ifndef RELAY_SCHEDULE_COUNTDOWN_TIMER_MACROS_SVH
`define RELAY_SCHEDULE_COUNTDOWN_TIMER_MACROS_SVH

// same-cycle implication, disabled during reset
`define RSCT_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, disabled during reset
`define RSCT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/rsct_pkg.sv -----
// types, codes and constants of the relay schedule countdown timer
package rsct_pkg;

  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned TIME_W       = 17;
  localparam int unsigned DUR_W        = 16;
  localparam int unsigned TPS_W        = 16;
  localparam int unsigned REM_W        = 32;
  localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_MANUAL    = 2'd1,
    OP_SCHEDULE  = 2'd2,
    OP_COUNTDOWN = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_MANUAL    = 2'd0,
    MODE_SCHEDULE  = 2'd1,
    MODE_COUNTDOWN = 2'd2
  } mode_e;

  typedef struct packed {
    op_e               op;
    logic [2:0]        channel;
    logic              switch_on;
    logic              schedule_active;
    logic              start_given;
    logic [TIME_W-1:0] start_time;
    logic              stop_given;
    logic [TIME_W-1:0] stop_time;
    logic [DUR_W-1:0]  duration_seconds;
    logic [TIME_W-1:0] time_of_day;
  } cmd_t;

  typedef struct packed {
    logic  relay;
    mode_e mode;
    logic  reported;
  } chan_stat_t;

  // daily window, wraps past midnight when start exceeds stop, equal means off
  function automatic logic window_on(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e,
                                     logic [TIME_W-1:0] now);
    logic on;
    on = 1'b0;
    if (s < e) begin
      on = (now >= s) && (now < e);
    end else if (s > e) begin
      on = (now >= s) || (now < e);
    end
    return on;
  endfunction

endpackage

// ----- design/rsct_channel.sv -----
// per-channel relay state, schedule window and countdown logic
module rsct_channel (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     sel_i,
  input  rsct_pkg::cmd_t           cmd_i,
  input  logic [rsct_pkg::TPS_W-1:0] tps_i,
  output rsct_pkg::chan_stat_t     stat_o
);
  import rsct_pkg::*;

  logic              relay_q, relay_d;
  mode_e             mode_q, mode_d;
  logic              start_valid_q, start_valid_d;
  logic              stop_valid_q, stop_valid_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [TIME_W-1:0] stop_q, stop_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic              target_q, target_d;
  logic              rep_q, rep_d;
  logic [REM_W-1:0]  load_val;
  logic              sched_set;
  logic [TIME_W-1:0] win_start;
  logic [TIME_W-1:0] win_stop;
  logic              want;

  assign load_val  = REM_W'(cmd_i.duration_seconds) * REM_W'(tps_i);
  assign sched_set = sel_i && (cmd_i.op == OP_SCHEDULE);
  assign win_start = (sched_set && cmd_i.start_given) ? cmd_i.start_time : start_q;
  assign win_stop  = (sched_set && cmd_i.stop_given) ? cmd_i.stop_time : stop_q;
  assign want      = window_on(win_start, win_stop, cmd_i.time_of_day);

  always_comb begin
    relay_d       = relay_q;
    mode_d        = mode_q;
    start_valid_d = start_valid_q;
    stop_valid_d  = stop_valid_q;
    start_d       = start_q;
    stop_d        = stop_q;
    rem_d         = rem_q;
    target_d      = target_q;
    rep_d         = 1'b0;
    unique case (cmd_i.op)
      OP_TICK: begin
        unique case (mode_q)
          MODE_SCHEDULE: begin
            if (start_valid_q && stop_valid_q && (want != relay_q)) begin
              relay_d = want;
              rep_d   = 1'b1;
            end
          end
          MODE_COUNTDOWN: begin
            if (rem_q != '0) begin
              rem_d = rem_q - REM_W'(1);
            end
            if (rem_q <= REM_W'(1)) begin
              relay_d = target_q;
              mode_d  = MODE_MANUAL;
              rep_d   = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      OP_MANUAL: begin
        if (sel_i) begin
          mode_d  = MODE_MANUAL;
          relay_d = cmd_i.switch_on;
          rep_d   = 1'b1;
        end
      end
      OP_SCHEDULE: begin
        if (sel_i) begin
          if (cmd_i.start_given) begin
            start_d       = cmd_i.start_time;
            start_valid_d = 1'b1;
          end
          if (cmd_i.stop_given) begin
            stop_d       = cmd_i.stop_time;
            stop_valid_d = 1'b1;
          end
          if (cmd_i.schedule_active) begin
            mode_d = MODE_SCHEDULE;
            if (start_valid_d && stop_valid_d) begin
              relay_d = want;
            end
          end else begin
            mode_d  = MODE_MANUAL;
            relay_d = 1'b0;
          end
          rep_d = 1'b1;
        end
      end
      OP_COUNTDOWN: begin
        if (sel_i && (cmd_i.duration_seconds != '0)) begin
          mode_d   = MODE_COUNTDOWN;
          target_d = cmd_i.switch_on;
          rem_d    = load_val;
          relay_d  = ~cmd_i.switch_on;
          rep_d    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q       <= 1'b0;
      mode_q        <= MODE_MANUAL;
      start_valid_q <= 1'b0;
      stop_valid_q  <= 1'b0;
      start_q       <= '0;
      stop_q        <= '0;
      rem_q         <= '0;
      target_q      <= 1'b0;
      rep_q         <= 1'b0;
    end else if (en_i) begin
      relay_q       <= relay_d;
      mode_q        <= mode_d;
      start_valid_q <= start_valid_d;
      stop_valid_q  <= stop_valid_d;
      start_q       <= start_d;
      stop_q        <= stop_d;
      rem_q         <= rem_d;
      target_q      <= target_d;
      rep_q         <= rep_d;
    end
  end

  assign stat_o.relay    = relay_q;
  assign stat_o.mode     = mode_q;
  assign stat_o.reported = rep_q;

endmodule

// ----- design/relay_schedule_countdown_timer.sv -----
// top level of the relay schedule countdown timer
//
//  port group     dir  width  content
//  s_axis_*       in   80+2   one command or tick per transaction
//  m_axis_*       out  32     relay states, modes and reported mask
//  cfg_*          in   16     ticks per second
//
// one transaction per cycle sustained while m_axis_tready is high; a result is valid
// after passing one input register and one state/result register per channel
// stalls on m_axis hold the state and back up through the input register
// reset clears all channel state and sets ticks per second to 1000
module relay_schedule_countdown_timer #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // channel, switch_on, schedule_active, start_given, start_time, stop_given,
  // stop_time, duration_seconds, time_of_day, zero pad
  input  logic [79:0] s_axis_tdata,
  // operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // relay_states, channel_modes, reported_mask
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import rsct_pkg::*;

  logic             in_valid_q;
  cmd_t             in_q;
  cmd_t             in_d;
  logic             out_valid_q;
  logic             adv;
  logic             fire;
  logic [TPS_W-1:0] tps_q;
  chan_stat_t       stat [CHANNELS];
  logic [MAX_CHANNELS-1:0]   relay_w;
  logic [2*MAX_CHANNELS-1:0] mode_w;
  logic [MAX_CHANNELS-1:0]   rep_w;

  assign adv           = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && adv;
  assign s_axis_tready = !in_valid_q || adv;
  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    in_d.op               = op_e'(s_axis_tuser);
    in_d.channel          = s_axis_tdata[2:0];
    in_d.switch_on        = s_axis_tdata[3];
    in_d.schedule_active  = s_axis_tdata[4];
    in_d.start_given      = s_axis_tdata[5];
    in_d.start_time       = s_axis_tdata[22:6];
    in_d.stop_given       = s_axis_tdata[23];
    in_d.stop_time        = s_axis_tdata[40:24];
    in_d.duration_seconds = s_axis_tdata[56:41];
    in_d.time_of_day      = s_axis_tdata[73:57];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tps_q       <= TPS_RESET;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_d;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    rsct_channel u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (fire),
      .sel_i  (in_q.channel == 3'(c)),
      .cmd_i  (in_q),
      .tps_i  (tps_q),
      .stat_o (stat[c])
    );
  end

  always_comb begin
    relay_w = '0;
    mode_w  = '0;
    rep_w   = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      relay_w[c]        = stat[c].relay;
      mode_w[2*c +: 2]  = stat[c].mode;
      rep_w[c]          = stat[c].reported;
    end
  end

  assign m_axis_tdata = {rep_w, mode_w, relay_w};

`include "relay_schedule_countdown_timer_macros.svh"

  `RSCT_ASSERT_NEXT(a_state_hold, clk_i, rst_ni, !fire, $stable(relay_w) && $stable(mode_w) && $stable(rep_w), "channel state moved without a transaction")
  `RSCT_ASSERT_NEXT(a_result_valid, clk_i, rst_ni, fire, m_axis_tvalid, "processed transaction gave no result")
  `RSCT_ASSERT_NEXT(a_manual_report, clk_i, rst_ni, fire && (in_q.op == OP_MANUAL) && (32'(in_q.channel) < CHANNELS), $onehot(rep_w), "manual set did not report exactly one channel")

endmodule
